// ----- rtl/mabt_pkg.sv -----
`timescale 1ns / 1ps

package mabt_pkg;

  localparam int PRICE_W    = 32;
  localparam int WLEN_W     = 7;
  localparam int PCT_W      = 15;
  localparam int MULT_W     = 16;
  localparam int PROD_W     = PRICE_W + MULT_W;
  localparam int QTY_W      = 16;
  localparam int PROFIT_W   = 64;
  localparam int CHG_W      = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // 100 percent in Q8.8
  localparam logic [MULT_W-1:0] PCT_ONE  = 16'd25600;
  localparam logic [QTY_W-1:0]  QTY_MAX  = 16'hFFFF;

  localparam logic [WLEN_W-1:0] WLEN_RST = 7'd20;
  localparam logic [PCT_W-1:0]  PCT_RST  = 15'd1280;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN   = 2'd0,
    REG_DOWN_PERCENT = 2'd1,
    REG_UP_PERCENT   = 2'd2
  } reg_idx_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SUM  = 8'b0000_0010,
    ST_DIVA = 8'b0000_0100,
    ST_MULB = 8'b0000_1000,
    ST_DIVB = 8'b0001_0000,
    ST_MULS = 8'b0010_0000,
    ST_DIVS = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  // status of a bit-serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } ser_sts_t;

endpackage

// ----- rtl/mabt_sdiv.sv -----
`timescale 1ns / 1ps

module mabt_sdiv #(
  parameter int DW = 48,
  parameter int VW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output mabt_pkg::ser_sts_t  sts,
  output logic [DW-1:0]       quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [VW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    q_r, q_nxt;
  logic [VW-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [VW:0]      shifted;
  logic [VW+1:0]    diff;
  logic             fits;

  // restoring division, one quotient bit per cycle, MSB first
  assign shifted = {rem_r, q_r[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = ~diff[VW+1];

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[VW-1:0] : shifted[VW-1:0];
      q_nxt   = {q_r[DW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;

endmodule

// ----- rtl/mabt_smul.sv -----
`timescale 1ns / 1ps

module mabt_smul #(
  parameter int AW = 32,
  parameter int BW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [AW-1:0]       mcand,
  input  logic [BW-1:0]       mplier,
  output mabt_pkg::ser_sts_t  sts,
  output logic [AW+BW-1:0]    product
);

  localparam int PW    = AW + BW;
  localparam int CNT_W = $clog2(BW + 1);

  logic [PW-1:0]    a_r, a_nxt;
  logic [BW-1:0]    b_r, b_nxt;
  logic [PW-1:0]    p_r, p_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  // shift-and-add, one multiplier bit per cycle, LSB first
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = PW'(mcand);
      b_nxt    = mplier;
      p_nxt    = '0;
      cnt_nxt  = CNT_W'(BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        p_nxt = p_r + a_r;
      end
      a_nxt   = {a_r[PW-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[BW-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = p_r;

endmodule

// ----- rtl/moving_average_band_trader_core.sv -----
`timescale 1ns / 1ps

// Moving-average envelope trader. Each accepted price (unsigned Q16.16) is
// compared against bands around the average of the window_len prices before
// it; one unit is bought at or below the buy band and one sold at or above
// the sell band, and the held quantity and signed profit are tracked. One
// price is worked at a time; the work for each is set by the bit-serial
// divider (average, buy band, sell band), the shift-add multiplier and the
// one-read-per-cycle sweep of the price ring over the stored prices summed
// (up to window_len). The next price is taken while a finished result waits
// on the output.
module moving_average_band_trader_core #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,

  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [mabt_pkg::PRICE_W-1:0]            in_price,

  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [mabt_pkg::PRICE_W-1:0]            out_average,
  output logic [mabt_pkg::PRICE_W-1:0]            out_buy_level,
  output logic [mabt_pkg::PRICE_W:0]              out_sell_level,
  output logic [1:0]                              out_action,
  output logic [mabt_pkg::QTY_W-1:0]              out_held_quantity,
  output logic signed [mabt_pkg::CHG_W-1:0]       out_profit_change,
  output logic signed [mabt_pkg::PROFIT_W-1:0]    out_total_profit,
  output logic                                    out_trading_active,

  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mabt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mabt_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int AW     = $clog2(WINDOW_MAX);
  localparam int CW     = $clog2(WINDOW_MAX + 1);
  localparam int LW     = (CW > mabt_pkg::WLEN_W) ? CW : mabt_pkg::WLEN_W;
  localparam int SUM_W  = mabt_pkg::PRICE_W + CW;
  localparam int DIV_W  = (SUM_W > mabt_pkg::PROD_W) ? SUM_W : mabt_pkg::PROD_W;
  localparam int DVS_W  = (CW > mabt_pkg::MULT_W) ? CW : mabt_pkg::MULT_W;
  localparam int PW     = mabt_pkg::PRICE_W;

  localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_MAX - 1);
  localparam logic [CW-1:0] SEEN_MAX = CW'(WINDOW_MAX);

  // configuration
  logic [mabt_pkg::WLEN_W-1:0] wlen_r;
  logic [mabt_pkg::PCT_W-1:0]  down_r;
  logic [mabt_pkg::PCT_W-1:0]  up_r;

  // control and working state
  mabt_pkg::state_t            state_r, state_nxt;
  logic [PW-1:0]               price_r, price_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]               rd_addr_r, rd_addr_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [PW-1:0]               avg_r, avg_nxt;
  logic [PW-1:0]               buy_r, buy_nxt;
  logic [PW:0]                 sell_r, sell_nxt;
  logic [AW-1:0]               ptr_r, ptr_nxt;
  logic [CW-1:0]               seen_r, seen_nxt;
  logic [mabt_pkg::QTY_W-1:0]  qty_r, qty_nxt;
  logic signed [mabt_pkg::PROFIT_W-1:0] total_r, total_nxt;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic [PW-1:0]               out_avg_r;
  logic [PW-1:0]               out_buy_r;
  logic [PW:0]                 out_sell_r;
  logic [1:0]                  out_action_r;
  logic [mabt_pkg::QTY_W-1:0]  out_qty_r;
  logic signed [mabt_pkg::CHG_W-1:0]    out_chg_r;
  logic signed [mabt_pkg::PROFIT_W-1:0] out_total_r;
  logic                        out_active_r;

  // price ring
  logic [PW-1:0]               ring_mem [WINDOW_MAX];
  logic [PW-1:0]               ring_q;
  logic                        rd_en;
  logic                        commit;

  // derived
  logic [LW-1:0]               wl_ext;
  logic [CW-1:0]               wl_eff;
  logic [CW-1:0]               n_sum;
  logic                        active;
  logic [mabt_pkg::PCT_W-1:0]  down_cl, up_cl;
  logic [mabt_pkg::MULT_W-1:0] buy_mult, sell_mult;
  logic                        buy_hit, sell_hit;
  logic [mabt_pkg::QTY_W-1:0]  qty_mid, qty_new;
  logic signed [mabt_pkg::CHG_W-1:0] chg;

  // serial units
  logic                        div_start, mul_start;
  logic [DIV_W-1:0]            div_a;
  logic [DVS_W-1:0]            div_b;
  logic [DIV_W-1:0]            div_q;
  mabt_pkg::ser_sts_t          div_sts, mul_sts;
  logic [PW-1:0]               mul_a;
  logic [mabt_pkg::MULT_W-1:0] mul_b;
  logic [mabt_pkg::PROD_W-1:0] mul_p;

  mabt_sdiv #(
    .DW (DIV_W),
    .VW (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .sts      (div_sts),
    .quotient (div_q)
  );

  mabt_smul #(
    .AW (PW),
    .BW (mabt_pkg::MULT_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .sts     (mul_sts),
    .product (mul_p)
  );

  // window length: zero reads as one, clamp to the ring depth
  assign wl_ext = LW'(wlen_r);
  always_comb begin
    if (wl_ext == '0) begin
      wl_eff = CW'(1);
    end else if (wl_ext > LW'(WINDOW_MAX)) begin
      wl_eff = SEEN_MAX;
    end else begin
      wl_eff = wl_ext[CW-1:0];
    end
  end

  assign n_sum  = (seen_r < wl_eff) ? seen_r : wl_eff;
  assign active = (seen_r >= wl_eff);

  assign down_cl   = (down_r > mabt_pkg::PCT_ONE[mabt_pkg::PCT_W-1:0]) ?
                     mabt_pkg::PCT_ONE[mabt_pkg::PCT_W-1:0] : down_r;
  assign up_cl     = (up_r > mabt_pkg::PCT_ONE[mabt_pkg::PCT_W-1:0]) ?
                     mabt_pkg::PCT_ONE[mabt_pkg::PCT_W-1:0] : up_r;
  assign buy_mult  = mabt_pkg::PCT_ONE - {1'b0, down_cl};
  assign sell_mult = mabt_pkg::PCT_ONE + {1'b0, up_cl};

  // operand steering for the shared units
  assign div_a = (state_r == mabt_pkg::ST_SUM) ? DIV_W'(sum_r) : DIV_W'(mul_p);
  assign div_b = (state_r == mabt_pkg::ST_SUM) ? DVS_W'(wl_eff) : DVS_W'(mabt_pkg::PCT_ONE);
  assign mul_a = (state_r == mabt_pkg::ST_DIVA) ? div_q[PW-1:0] : avg_r;
  assign mul_b = (state_r == mabt_pkg::ST_DIVA) ? buy_mult : sell_mult;

  // trade decision
  assign buy_hit  = active && (price_r <= buy_r) && (qty_r != mabt_pkg::QTY_MAX);
  assign qty_mid  = qty_r + mabt_pkg::QTY_W'(buy_hit);
  assign sell_hit = active && ({1'b0, price_r} >= sell_r) && (qty_mid != '0);
  assign qty_new  = qty_mid - mabt_pkg::QTY_W'(sell_hit);

  always_comb begin
    if (sell_hit && !buy_hit) begin
      chg = $signed({1'b0, price_r});
    end else if (buy_hit && !sell_hit) begin
      chg = -$signed({1'b0, price_r});
    end else begin
      chg = '0;
    end
  end

  assign rd_en  = (state_r == mabt_pkg::ST_SUM) && (cnt_r != '0);
  assign commit = (state_r == mabt_pkg::ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt   = state_r;
    price_nxt   = price_r;
    cnt_nxt     = cnt_r;
    rd_addr_nxt = rd_addr_r;
    rd_vld_nxt  = 1'b0;
    sum_nxt     = sum_r;
    avg_nxt     = avg_r;
    buy_nxt     = buy_r;
    sell_nxt    = sell_r;
    ptr_nxt     = ptr_r;
    seen_nxt    = seen_r;
    qty_nxt     = qty_r;
    total_nxt   = total_r;
    div_start   = 1'b0;
    mul_start   = 1'b0;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;

    unique case (state_r)
      mabt_pkg::ST_IDLE: begin
        if (in_valid) begin
          price_nxt   = in_price;
          cnt_nxt     = n_sum;
          rd_addr_nxt = (ptr_r == '0) ? PTR_LAST : ptr_r - 1'b1;
          sum_nxt     = '0;
          state_nxt   = mabt_pkg::ST_SUM;
        end
      end
      mabt_pkg::ST_SUM: begin
        // walk back through the ring, one read per cycle
        rd_vld_nxt = rd_en;
        if (rd_en) begin
          cnt_nxt     = cnt_r - 1'b1;
          rd_addr_nxt = (rd_addr_r == '0) ? PTR_LAST : rd_addr_r - 1'b1;
        end
        if (rd_vld_r) begin
          sum_nxt = sum_r + SUM_W'(ring_q);
        end
        if (!rd_en && !rd_vld_r) begin
          div_start = 1'b1;
          state_nxt = mabt_pkg::ST_DIVA;
        end
      end
      mabt_pkg::ST_DIVA: begin
        if (div_sts.done) begin
          avg_nxt   = div_q[PW-1:0];
          mul_start = 1'b1;
          state_nxt = mabt_pkg::ST_MULB;
        end
      end
      mabt_pkg::ST_MULB: begin
        if (mul_sts.done) begin
          div_start = 1'b1;
          state_nxt = mabt_pkg::ST_DIVB;
        end
      end
      mabt_pkg::ST_DIVB: begin
        if (div_sts.done) begin
          buy_nxt   = div_q[PW-1:0];
          mul_start = 1'b1;
          state_nxt = mabt_pkg::ST_MULS;
        end
      end
      mabt_pkg::ST_MULS: begin
        if (mul_sts.done) begin
          div_start = 1'b1;
          state_nxt = mabt_pkg::ST_DIVS;
        end
      end
      mabt_pkg::ST_DIVS: begin
        if (div_sts.done) begin
          sell_nxt  = div_q[PW:0];
          state_nxt = mabt_pkg::ST_DONE;
        end
      end
      mabt_pkg::ST_DONE: begin
        // hold until the result register is free
        if (commit) begin
          ptr_nxt       = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
          seen_nxt      = (seen_r < SEEN_MAX) ? seen_r + 1'b1 : seen_r;
          qty_nxt       = qty_new;
          total_nxt     = total_r +
                          {{(mabt_pkg::PROFIT_W - mabt_pkg::CHG_W){chg[mabt_pkg::CHG_W-1]}},
                           chg};
          out_valid_nxt = 1'b1;
          state_nxt     = mabt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mabt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mabt_pkg::ST_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      ptr_r       <= '0;
      seen_r      <= '0;
      qty_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      ptr_r       <= ptr_nxt;
      seen_r      <= seen_nxt;
      qty_r       <= qty_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r   <= price_nxt;
    rd_addr_r <= rd_addr_nxt;
    sum_r     <= sum_nxt;
    avg_r     <= avg_nxt;
    buy_r     <= buy_nxt;
    sell_r    <= sell_nxt;
    if (commit) begin
      out_avg_r    <= avg_r;
      out_buy_r    <= buy_r;
      out_sell_r   <= sell_r;
      out_action_r <= {sell_hit, buy_hit};
      out_qty_r    <= qty_new;
      out_chg_r    <= chg;
      out_total_r  <= total_nxt;
      out_active_r <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      ring_mem[ptr_r] <= price_r;
    end
    if (rd_en) begin
      ring_q <= ring_mem[rd_addr_r];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= mabt_pkg::WLEN_RST;
      down_r <= mabt_pkg::PCT_RST;
      up_r   <= mabt_pkg::PCT_RST;
    end else if (cfg_valid) begin
      unique case (mabt_pkg::reg_idx_t'(cfg_index))
        mabt_pkg::REG_WINDOW_LEN:   wlen_r <= cfg_data[mabt_pkg::WLEN_W-1:0];
        mabt_pkg::REG_DOWN_PERCENT: down_r <= cfg_data[mabt_pkg::PCT_W-1:0];
        mabt_pkg::REG_UP_PERCENT:   up_r   <= cfg_data[mabt_pkg::PCT_W-1:0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == mabt_pkg::ST_IDLE);

  assign out_valid          = out_valid_r;
  assign out_average        = out_avg_r;
  assign out_buy_level      = out_buy_r;
  assign out_sell_level     = out_sell_r;
  assign out_action         = out_action_r;
  assign out_held_quantity  = out_qty_r;
  assign out_profit_change  = out_chg_r;
  assign out_total_profit   = out_total_r;
  assign out_trading_active = out_active_r;

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_sts.busy && mul_sts.busy))
    else $error("divider and multiplier busy together");

  a_warmup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_active_r |-> (out_action_r == 2'b00) && (out_chg_r == '0))
    else $error("trade reported before a full window");

  a_change_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_chg_r != '0) |-> (out_action_r == 2'b01) || (out_action_r == 2'b10))
    else $error("cash change without a single trade");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= SEEN_MAX)
    else $error("price count past ring depth");

endmodule

// ----- verif/moving_average_band_trader_core_tb.sv -----
`timescale 1ns / 1ps

module moving_average_band_trader_core_tb;

  localparam int WINDOW_MAX = 64;
  localparam longint unsigned PCT_FULL = 64'd25600;
  localparam logic [15:0] UNITS_FULL = 16'hFFFF;
  localparam logic [mabt_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int SEGMENTS = 12;
  localparam int SEGMENT_TICKS = 112;

  typedef struct packed {
    logic [31:0] average;
    logic [31:0] buy_level;
    logic [32:0] sell_level;
    logic [1:0]  action;
    logic [15:0] held_quantity;
    logic [32:0] profit_change;
    logic [63:0] total_profit;
    logic        trading_active;
  } tick_result_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [mabt_pkg::PRICE_W-1:0]         in_price;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [mabt_pkg::PRICE_W-1:0]         out_average;
  logic [mabt_pkg::PRICE_W-1:0]         out_buy_level;
  logic [mabt_pkg::PRICE_W:0]           out_sell_level;
  logic [1:0]                           out_action;
  logic [mabt_pkg::QTY_W-1:0]           out_held_quantity;
  logic signed [mabt_pkg::CHG_W-1:0]    out_profit_change;
  logic signed [mabt_pkg::PROFIT_W-1:0] out_total_profit;
  logic                                 out_trading_active;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [mabt_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [mabt_pkg::CFG_DATA_W-1:0]      cfg_data;

  // band trader state as the block should hold it
  logic [31:0] price_hist [WINDOW_MAX];
  logic [5:0]  hist_ptr;
  logic [6:0]  hist_seen;
  logic [15:0] held_units;
  logic [63:0] cash_total;
  logic [6:0]  band_wlen;
  logic [14:0] band_down;
  logic [14:0] band_up;

  tick_result_t expected_ticks [$];
  tick_result_t next_tick;
  int error_count = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;

  moving_average_band_trader_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_price           (in_price),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_average        (out_average),
    .out_buy_level      (out_buy_level),
    .out_sell_level     (out_sell_level),
    .out_action         (out_action),
    .out_held_quantity  (out_held_quantity),
    .out_profit_change  (out_profit_change),
    .out_total_profit   (out_total_profit),
    .out_trading_active (out_trading_active),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic reset_bands();
    for (int i = 0; i < WINDOW_MAX; i++) price_hist[i] = 32'd0;
    hist_ptr = 6'd0;
    hist_seen = 7'd0;
    held_units = 16'd0;
    cash_total = 64'd0;
    band_wlen = 7'd20;
    band_down = 15'd1280;
    band_up = 15'd1280;
  endtask

  task automatic predict_tick(input logic [31:0] price, output tick_result_t r);
    int unsigned wl;
    int unsigned n;
    logic [5:0]  slot;
    logic [63:0] sum;
    logic [63:0] avg;
    logic [63:0] buy;
    logic [63:0] sell;
    logic [63:0] chg;
    logic [63:0] dn;
    logic [63:0] upv;
    logic [15:0] old_units;
    logic [1:0]  act;
    logic        active;
    sum = 64'd0;
    chg = 64'd0;
    act = 2'b00;
    wl = (band_wlen == 0) ? 1 : (band_wlen > WINDOW_MAX) ? WINDOW_MAX : band_wlen;
    n = (hist_seen < wl) ? hist_seen : wl;
    // sum the n most recent prices, newest first
    for (int t = 1; t <= n; t++) begin
      slot = 6'(hist_ptr - t);
      sum = sum + {32'd0, price_hist[slot]};
    end
    avg = sum / wl;
    dn = (band_down > PCT_FULL) ? PCT_FULL : {49'd0, band_down};
    upv = (band_up > PCT_FULL) ? PCT_FULL : {49'd0, band_up};
    buy = avg * (PCT_FULL - dn) / PCT_FULL;
    sell = avg * (PCT_FULL + upv) / PCT_FULL;
    active = (hist_seen >= wl);
    if (active) begin
      old_units = held_units;
      if ({32'd0, price} <= buy && held_units != UNITS_FULL) begin
        held_units = held_units + 16'd1;
        act[0] = 1'b1;
      end
      if ({32'd0, price} >= sell && held_units != 16'd0) begin
        held_units = held_units - 16'd1;
        act[1] = 1'b1;
      end
      if (held_units < old_units) chg = {32'd0, price};
      else if (held_units > old_units) chg = 64'd0 - {32'd0, price};
      cash_total = cash_total + chg;
    end
    price_hist[hist_ptr] = price;
    hist_ptr = hist_ptr + 6'd1;
    if (hist_seen < WINDOW_MAX) hist_seen = hist_seen + 7'd1;
    r.average = avg[31:0];
    r.buy_level = buy[31:0];
    r.sell_level = sell[32:0];
    r.action = act;
    r.held_quantity = held_units;
    r.profit_change = chg[32:0];
    r.total_profit = cash_total;
    r.trading_active = active;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet) return 0;
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 4);
    if (roll < 96) return $urandom_range(5, 15);
    return $urandom_range(40, 200);
  endfunction

  function automatic logic [14:0] pick_pct();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 15'($urandom_range(0, 3000));
    if (roll < 8) return 15'($urandom_range(0, 25600));
    if (roll == 8) return ($urandom_range(0, 1) != 0) ? 15'd25600 : 15'd0;
    return 15'($urandom_range(25601, 32767));
  endfunction

  task automatic send_price(input logic [31:0] price);
    int gap;
    tick_result_t r;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_price <= price;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(price, r);
    expected_ticks = {expected_ticks, r};
  endtask

  task automatic write_reg(input logic [mabt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [14:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mabt_pkg::REG_WINDOW_LEN:   band_wlen = val[6:0];
      mabt_pkg::REG_DOWN_PERCENT: band_down = val;
      mabt_pkg::REG_UP_PERCENT:   band_up = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid and hold until every pending result word has been taken
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        $error("result word with no price pending");
        error_count++;
      end else begin
        next_tick = expected_ticks.pop_front();
        check_field("average", next_tick.average, out_average);
        check_field("buy_level", next_tick.buy_level, out_buy_level);
        check_field("sell_level", next_tick.sell_level, out_sell_level);
        check_field("action", next_tick.action, out_action);
        check_field("held_quantity", next_tick.held_quantity, out_held_quantity);
        check_field("profit_change", next_tick.profit_change, $unsigned(out_profit_change));
        check_field("total_profit", next_tick.total_profit, $unsigned(out_total_profit));
        check_field("trading_active", next_tick.trading_active, out_trading_active);
      end
    end
  end

  // result side: runs of ready broken by random stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // warm-up under the reset settings: partial sum still divided by 20
  task automatic test_warmup_defaults();
    send_price(32'h0064_0000);
    send_price(32'h00C8_0000);
    send_price(32'h012C_0000);
  endtask

  task automatic test_price_extremes();
    wait_idle();
    // upper data bits set, only the low seven count: window of 2
    write_reg(mabt_pkg::REG_WINDOW_LEN, 15'h7F82);
    send_price(32'hFFFF_FFFF);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0000);
    send_price(32'hFFFF_FFFF);
  endtask

  task automatic test_band_limits();
    wait_idle();
    write_reg(mabt_pkg::REG_WINDOW_LEN, 15'd0);
    write_reg(mabt_pkg::REG_DOWN_PERCENT, 15'd0);
    write_reg(mabt_pkg::REG_UP_PERCENT, 15'd0);
    // zero-width bands: a flat price buys and sells in one step
    send_price(32'h04D2_0000);
    send_price(32'h04D2_0000);
    wait_idle();
    write_reg(mabt_pkg::REG_DOWN_PERCENT, 15'd25600);
    write_reg(mabt_pkg::REG_UP_PERCENT, 15'd25600);
    send_price(32'h0000_0000);
    send_price(32'hFFFF_FFFF);
    wait_idle();
    write_reg(mabt_pkg::REG_DOWN_PERCENT, 15'h7FFF);
    write_reg(mabt_pkg::REG_UP_PERCENT, 15'h7FFF);
    send_price(32'h0000_0000);
    send_price(32'h0000_0005);
  endtask

  task automatic test_window_limits();
    wait_idle();
    write_reg(mabt_pkg::REG_WINDOW_LEN, 15'd127);
    send_price(32'h1234_5678);
    send_price(32'h8765_4321);
    wait_idle();
    write_reg(mabt_pkg::REG_WINDOW_LEN, 15'd64);
    send_price(32'h0001_0000);
    send_price(32'hFFFF_0000);
  endtask

  task automatic test_spare_index();
    wait_idle();
    write_reg(REG_SPARE, 15'h7FFF);
    send_price(32'h5555_AAAA);
  endtask

  task automatic pick_bands();
    logic [14:0] wl_word;
    int roll;
    roll = $urandom_range(0, 9);
    wl_word = 15'($urandom);
    if (roll < 6) wl_word[6:0] = 7'($urandom_range(1, 8));
    else if (roll < 8) wl_word[6:0] = 7'($urandom_range(9, 64));
    else if (roll == 8) wl_word[6:0] = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'd0;
    else wl_word[6:0] = 7'($urandom_range(65, 127));
    write_reg(mabt_pkg::REG_WINDOW_LEN, wl_word);
    write_reg(mabt_pkg::REG_DOWN_PERCENT, pick_pct());
    write_reg(mabt_pkg::REG_UP_PERCENT, pick_pct());
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 15'($urandom));
  endtask

  // trending random walks with noise words mixed in
  task automatic test_random_market();
    logic [63:0] lvl;
    logic [63:0] stepv;
    logic [63:0] mv;
    int trend;
    int roll;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      pick_bands();
      quiet = (seg % 5 == 2);
      trend = int'($urandom_range(0, 2)) - 1;
      case ($urandom_range(0, 2))
        0: lvl = 64'($urandom_range(0, 32'h0001_0000));
        1: lvl = 64'($urandom);
        default: lvl = 64'hFFFF_FFFF - 64'($urandom_range(0, 32'h00FF_FFFF));
      endcase
      for (int k = 0; k < SEGMENT_TICKS; k++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_price($urandom);
        end else begin
          stepv = (lvl >> $urandom_range(3, 6)) + 64'd1;
          mv = stepv * $urandom_range(0, 100) / 100;
          roll = $urandom_range(0, 99);
          if (roll < 50 + 15 * trend) begin
            lvl = (lvl + mv > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : lvl + mv;
          end else begin
            lvl = (mv > lvl) ? 64'd0 : lvl - mv;
          end
          send_price(lvl[31:0]);
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    in_valid = 1'b0;
    in_price = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    reset_bands();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_warmup_defaults();
    test_price_extremes();
    test_band_limits();
    test_window_limits();
    test_spare_index();
    test_random_market();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
